// ===== rtl/core/address_region_map_table_top_assert.svh =====
// assertion macros for the address region map table checker
// expects clk and rst_n in the scope of each use
`ifndef ADDRESS_REGION_MAP_TABLE_TOP_ASSERT_SVH
`define ADDRESS_REGION_MAP_TABLE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define ARMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("armt assertion failed");

// next-cycle implication, off during reset
`define ARMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("armt assertion failed");

`endif

// ===== rtl/core/armt_pkg.sv =====
// shared types and codes for the address region map table
// no dependencies
package armt_pkg;

  localparam int ADDR_W = 32;
  localparam int PART_W = 8;
  localparam int STAT_W = 2;
  localparam int OIDX_W = 4;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] ST_APPENDED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_HIT      = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS     = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [PART_W-1:0] partition;
    logic [ADDR_W-1:0] permission;
    logic [ADDR_W-1:0] sector;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/address_region_map_table_top.sv =====
// an append goes from accept straight to S_POST; a lookup goes to S_SCAN (straight to S_POST on an
// empty table), one slot compared per cycle through the table ram, up to the first hit or the last entry
// one transaction at a time, taken again once S_POST has registered the result;
// a stalled result holds input
// reset: synchronous active low, empties the table; entries are not cleared
// depends on armt_pkg and armt_ram
module address_region_map_table_top
  import armt_pkg::*;
#(
  parameter int MAX_MAPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [ADDR_W-1:0] in_lookup_addr,
  input  logic [ADDR_W-1:0] in_region_start,
  input  logic [ADDR_W-1:0] in_region_size,
  input  logic [PART_W-1:0] in_partition_id,
  input  logic [ADDR_W-1:0] in_permission,
  input  logic [ADDR_W-1:0] in_start_sector,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [OIDX_W-1:0] out_entry_index,
  output logic [ADDR_W-1:0] out_hit_start,
  output logic [ADDR_W-1:0] out_hit_size,
  output logic [PART_W-1:0] out_hit_partition,
  output logic [ADDR_W-1:0] out_hit_permission,
  output logic [ADDR_W-1:0] out_hit_sector
);

  localparam int IDX_W = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
  localparam int CNT_W = $clog2(MAX_MAPS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MAPS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  entry_t            res_ent_r, res_ent_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  entry_t            out_ent_r, out_ent_nxt;

  logic              wr_en;
  entry_t            wr_ent;
  entry_t            rd_ent;
  logic [IDX_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  scan_inc;
  logic [ADDR_W-1:0] rd_end;
  logic              hit;
  logic              out_free;
  logic [IDX_W+3:0]  idx_ext;

  assign wr_ent = '{start:      in_region_start,
                    size:       in_region_size,
                    partition:  in_partition_id,
                    permission: in_permission,
                    sector:     in_start_sector};

  armt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_MAPS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_ent),
    .rd_addr (rd_addr),
    .rd_data (rd_ent)
  );

  assign in_ready = (state_r == S_IDLE);
  assign scan_inc = scan_idx_r + 1'b1;
  assign rd_end   = rd_ent.start + rd_ent.size;
  assign hit      = (addr_r >= rd_ent.start) && (addr_r < rd_end);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    addr_nxt       = addr_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_ent_nxt    = res_ent_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_ent_nxt    = out_ent_r;
    wr_en          = 1'b0;
    rd_addr        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_idx_nxt = '0;
          res_ent_nxt = '0;
          if (in_action == ACT_APPEND) begin
            if (count_r == CNT_MAX) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_en          = 1'b1;
              res_status_nxt = ST_APPENDED;
              res_idx_nxt    = count_r[IDX_W-1:0];
              count_nxt      = count_r + 1'b1;
            end
            state_nxt = S_POST;
          end else begin
            addr_nxt = in_lookup_addr;
            if (count_r == '0) begin
              res_status_nxt = ST_MISS;
              state_nxt      = S_POST;
            end else begin
              scan_idx_nxt = '0;
              state_nxt    = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        rd_addr = scan_inc[IDX_W-1:0];
        if (hit) begin
          res_status_nxt = ST_HIT;
          res_idx_nxt    = scan_idx_r[IDX_W-1:0];
          res_ent_nxt    = rd_ent;
          state_nxt      = S_POST;
        end else if (scan_inc == count_r) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_POST;
        end else begin
          scan_idx_nxt = scan_inc;
        end
      end
      S_POST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_ent_nxt    = res_ent_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    addr_r       <= addr_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_ent_r    <= res_ent_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_ent_r    <= out_ent_nxt;
  end

  assign idx_ext = {4'b0, out_idx_r};

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_index    = idx_ext[OIDX_W-1:0];
  assign out_hit_start      = out_ent_r.start;
  assign out_hit_size       = out_ent_r.size;
  assign out_hit_partition  = out_ent_r.partition;
  assign out_hit_permission = out_ent_r.permission;
  assign out_hit_sector     = out_ent_r.sector;

endmodule

// ===== rtl/core/armt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module armt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/armt_checker.sv =====
// port-level checks for the address region map table, bound to the top level
// depends on armt_pkg and address_region_map_table_top_assert.svh
`include "address_region_map_table_top_assert.svh"

module armt_checker
  import armt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_action,
  input logic [ADDR_W-1:0] in_lookup_addr,
  input logic [ADDR_W-1:0] in_region_start,
  input logic [ADDR_W-1:0] in_region_size,
  input logic [PART_W-1:0] in_partition_id,
  input logic [ADDR_W-1:0] in_permission,
  input logic [ADDR_W-1:0] in_start_sector,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [OIDX_W-1:0] out_entry_index,
  input logic [ADDR_W-1:0] out_hit_start,
  input logic [ADDR_W-1:0] out_hit_size,
  input logic [PART_W-1:0] out_hit_partition,
  input logic [ADDR_W-1:0] out_hit_permission,
  input logic [ADDR_W-1:0] out_hit_sector
);

  logic non_hit;
  logic fields_zero;

  assign non_hit     = (out_status == ST_APPENDED) || (out_status == ST_FULL) ||
                       (out_status == ST_MISS);
  assign fields_zero = (out_hit_start == '0) && (out_hit_size == '0) &&
                       (out_hit_partition == '0) && (out_hit_permission == '0) &&
                       (out_hit_sector == '0);

  // stalled result transaction holds
  `ARMT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ARMT_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_status) && $stable(out_entry_index))
  // only a hit carries region fields
  `ARMT_ASSERT_IMP(a_nonhit_zero, out_valid && non_hit, fields_zero)
  // full and miss report slot zero
  `ARMT_ASSERT_IMP(a_noslot_zero, out_valid && ((out_status == ST_FULL) || (out_status == ST_MISS)), out_entry_index == '0)

endmodule

bind address_region_map_table_top armt_checker u_armt_checker (.*);
